// ===== hw/rtl/iexu_pkg.sv =====
// Package for the integer execute unit: operation codes, item structs,
// and the mapping from operation code to ALU operation.
// No dependencies.
`default_nettype none

package iexu_pkg;

   localparam int unsigned XLEN       = 32;
   localparam int unsigned FUNC_W     = 5;
   localparam int unsigned REG_IDX_W  = 5;
   localparam int unsigned SHAMT_W    = 5;
   localparam int unsigned WORD_SHIFT = 2;   // offsets count 4-byte words
   localparam int unsigned UPPER_SHIFT = 12;
   localparam logic [XLEN-1:0] WORD_BYTES = XLEN'(4);

   // Operation codes carried in the func field
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 5'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB   = 5'd1;
   localparam logic [FUNC_W-1:0] FUNC_AND   = 5'd2;
   localparam logic [FUNC_W-1:0] FUNC_OR    = 5'd3;
   localparam logic [FUNC_W-1:0] FUNC_XOR   = 5'd4;
   localparam logic [FUNC_W-1:0] FUNC_SLL   = 5'd5;
   localparam logic [FUNC_W-1:0] FUNC_SRL   = 5'd6;
   localparam logic [FUNC_W-1:0] FUNC_SRA   = 5'd7;
   localparam logic [FUNC_W-1:0] FUNC_SLT   = 5'd8;
   localparam logic [FUNC_W-1:0] FUNC_SLTU  = 5'd9;
   localparam logic [FUNC_W-1:0] FUNC_ADDI  = 5'd10;
   localparam logic [FUNC_W-1:0] FUNC_ANDI  = 5'd11;
   localparam logic [FUNC_W-1:0] FUNC_ORI   = 5'd12;
   localparam logic [FUNC_W-1:0] FUNC_XORI  = 5'd13;
   localparam logic [FUNC_W-1:0] FUNC_SLLI  = 5'd14;
   localparam logic [FUNC_W-1:0] FUNC_SRLI  = 5'd15;
   localparam logic [FUNC_W-1:0] FUNC_SRAI  = 5'd16;
   localparam logic [FUNC_W-1:0] FUNC_SLTI  = 5'd17;
   localparam logic [FUNC_W-1:0] FUNC_SLTIU = 5'd18;
   localparam logic [FUNC_W-1:0] FUNC_LUI   = 5'd19;
   localparam logic [FUNC_W-1:0] FUNC_AUIPC = 5'd20;
   localparam logic [FUNC_W-1:0] FUNC_JAL   = 5'd21;
   localparam logic [FUNC_W-1:0] FUNC_JALR  = 5'd22;
   localparam logic [FUNC_W-1:0] FUNC_BEQ   = 5'd23;
   localparam logic [FUNC_W-1:0] FUNC_BNE   = 5'd24;
   localparam logic [FUNC_W-1:0] FUNC_BLT   = 5'd25;
   localparam logic [FUNC_W-1:0] FUNC_BGE   = 5'd26;
   localparam logic [FUNC_W-1:0] FUNC_BLTU  = 5'd27;
   localparam logic [FUNC_W-1:0] FUNC_BGEU  = 5'd28;

   // Internal ALU operations
   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR,
      ALU_SLL, ALU_SRL, ALU_SRA, ALU_SLT, ALU_SLTU,
      ALU_LUI, ALU_AUIPC, ALU_LINK, ALU_NONE
   } alu_op_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic signed [XLEN-1:0] src1;
      logic signed [XLEN-1:0] src2;
      logic signed [XLEN-1:0] imm;
      logic [REG_IDX_W-1:0] dest_reg;
      logic [XLEN-1:0]      pc;
   } req_type;

   typedef struct packed {
      logic signed [XLEN-1:0] result;
      logic                 write_enable;
      logic [REG_IDX_W-1:0] write_index;
      logic [XLEN-1:0]      next_pc;
      logic                 branch_taken;
   } rsp_type;

   // Control-flow outcome handed from the branch unit to the top level
   typedef struct packed {
      logic [XLEN-1:0] next_pc;
      logic            branch_taken;
   } flow_type;

   // Operation code to ALU operation; immediate forms share the register ops
   function automatic alu_op_type alu_op(input logic [FUNC_W-1:0] func);
      alu_op_type op;
      begin
         case (func)
            FUNC_ADD, FUNC_ADDI:   op = ALU_ADD;
            FUNC_SUB:              op = ALU_SUB;
            FUNC_AND, FUNC_ANDI:   op = ALU_AND;
            FUNC_OR, FUNC_ORI:     op = ALU_OR;
            FUNC_XOR, FUNC_XORI:   op = ALU_XOR;
            FUNC_SLL, FUNC_SLLI:   op = ALU_SLL;
            FUNC_SRL, FUNC_SRLI:   op = ALU_SRL;
            FUNC_SRA, FUNC_SRAI:   op = ALU_SRA;
            FUNC_SLT, FUNC_SLTI:   op = ALU_SLT;
            FUNC_SLTU, FUNC_SLTIU: op = ALU_SLTU;
            FUNC_LUI:              op = ALU_LUI;
            FUNC_AUIPC:            op = ALU_AUIPC;
            FUNC_JAL, FUNC_JALR:   op = ALU_LINK;
            default:               op = ALU_NONE;
         endcase
         return op;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/iexu_alu.sv =====
// Register result path of the integer execute unit: ALU, upper immediates
// and link value. Depends on iexu_pkg.
`default_nettype none

module iexu_alu import iexu_pkg::*; (
   input  wire req_type          req,
   output logic signed [XLEN-1:0] result,
   output logic                  write_enable
);

   alu_op_type      op;
   logic [XLEN-1:0] a;
   logic [XLEN-1:0] b;
   logic [SHAMT_W-1:0] shamt;
   logic [XLEN-1:0] upper;

   // Immediate forms take imm as second operand
   always_comb begin
      op    = alu_op(req.func);
      a     = req.src1;
      b     = (req.func <= FUNC_SLTU) ? req.src2 : req.imm;
      shamt = b[SHAMT_W-1:0];
      upper = XLEN'(req.imm) << UPPER_SHIFT;
   end

   // Result select
   always_comb begin
      write_enable = 1'b1;
      case (op)
         ALU_ADD:   result = a + b;
         ALU_SUB:   result = a - b;
         ALU_AND:   result = a & b;
         ALU_OR:    result = a | b;
         ALU_XOR:   result = a ^ b;
         ALU_SLL:   result = a << shamt;
         ALU_SRL:   result = a >> shamt;
         ALU_SRA:   result = $signed(a) >>> shamt;
         ALU_SLT:   result = XLEN'($signed(a) < $signed(b));
         ALU_SLTU:  result = XLEN'(a < b);
         ALU_LUI:   result = upper;
         ALU_AUIPC: result = req.pc + upper;
         ALU_LINK:  result = req.pc + WORD_BYTES;
         default: begin
            result       = '0;
            write_enable = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/iexu_branch.sv =====
// Next-pc path of the integer execute unit: branch compares, jump targets
// and the sequential pc. Depends on iexu_pkg.
`default_nettype none

module iexu_branch import iexu_pkg::*; (
   input  wire req_type  req,
   output flow_type      flow
);

   logic [XLEN-1:0] a;
   logic [XLEN-1:0] b;
   logic [XLEN-1:0] offs;
   logic [XLEN-1:0] pc_target;
   logic            eq;
   logic            lt_s;
   logic            lt_u;

   // Compares and targets
   always_comb begin
      a         = req.src1;
      b         = req.src2;
      offs      = XLEN'(req.imm) << WORD_SHIFT;
      pc_target = req.pc + offs;
      eq        = (a == b);
      lt_s      = $signed(a) < $signed(b);
      lt_u      = a < b;
   end

   // Direction select
   always_comb begin
      flow.next_pc      = req.pc + WORD_BYTES;
      flow.branch_taken = 1'b0;
      case (req.func)
         FUNC_JAL: begin
            flow.next_pc      = pc_target;
            flow.branch_taken = 1'b1;
         end
         FUNC_JALR: begin
            flow.next_pc      = a + offs;
            flow.branch_taken = 1'b1;
         end
         FUNC_BEQ:  flow.branch_taken = eq;
         FUNC_BNE:  flow.branch_taken = !eq;
         FUNC_BLT:  flow.branch_taken = lt_s;
         FUNC_BGE:  flow.branch_taken = !lt_s;
         FUNC_BLTU: flow.branch_taken = lt_u;
         FUNC_BGEU: flow.branch_taken = !lt_u;
         default:   flow.branch_taken = 1'b0;
      endcase
      if (flow.branch_taken && req.func != FUNC_JALR) begin
         flow.next_pc = pc_target;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_execute_unit.sv =====
// Top level of the integer execute unit: input register, ALU and branch
// paths, result register. Depends on iexu_pkg, iexu_alu, iexu_branch.
`default_nettype none

// An item is taken on any clock edge where start is high and busy is low;
// busy is high only while reset is held, so a new item may be given every
// cycle. Each item gives exactly one result: it passes the input register,
// then the ALU and branch logic, and is held in the result register.
// rsp_strobe marks the result for a single cycle and results
// appear in item order; the receiver cannot stall, so it must take each
// result in the cycle it is shown.
module integer_execute_unit import iexu_pkg::*; (
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   output logic     busy,
   input  wire req_type req_item,
   output logic     rsp_strobe,
   output rsp_type  rsp_item
);

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [XLEN-1:0] alu_result;
   logic                   alu_we;
   flow_type               flow;

   assign busy = reset;

   // Input register
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_item;
      end
   end

   iexu_alu u_alu (
      .req          (req_ff),
      .result       (alu_result),
      .write_enable (alu_we)
   );

   iexu_branch u_branch (
      .req  (req_ff),
      .flow (flow)
   );

   // Result register
   always_comb begin
      rsp_valid_in         = req_valid_ff;
      rsp_in.result        = alu_result;
      rsp_in.write_enable  = alu_we;
      rsp_in.write_index   = req_ff.dest_reg;
      rsp_in.next_pc       = flow.next_pc;
      rsp_in.branch_taken  = flow.branch_taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // Every accepted item shows its result once through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted item produced no result");

   // No result without an item in the input register the cycle before
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_valid_ff))
      else $error("result strobe without an item");

   // Non-writing results carry a zero value
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.write_enable) |-> (rsp_item.result == '0))
      else $error("non-writing item has nonzero result");

   // A taken write is a jump, which links pc + 4
   a_seq_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.write_enable && rsp_item.branch_taken)
         |-> (rsp_item.result == $past(req_ff.pc) + WORD_BYTES))
      else $error("jump link value is not pc + 4");

endmodule

`default_nettype wire
